[rtl/core/olpfr_pkg.sv]
// ----------------------------------------------------------------------------
// olpfr_pkg
// Shared types and constants of the ordered list core: operation and status
// codes, sequencer states, field widths and the result bundle.
// ----------------------------------------------------------------------------
package olpfr_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int TOTAL_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH     = 2'd0,
        KIND_FIND     = 2'd1,
        KIND_REMOVE   = 2'd2,
        KIND_RESERVED = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_BOUNDS    = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t              status;
        logic [FOUND_W-1:0]   found_position;
        logic [TOTAL_W-1:0]   entry_total;
    } result_t;

endpackage

[rtl/core/olpfr_ram.sv]
// ----------------------------------------------------------------------------
// olpfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module olpfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/olpfr_ctrl.sv]
// ----------------------------------------------------------------------------
// olpfr_ctrl
// Sequencer of the ordered list: owns the entry count and one index counter
// that walks the entry RAM for find (read, compare) and remove (read, write).
// ----------------------------------------------------------------------------
module olpfr_ctrl #(
    parameter int TABLE_DEPTH = olpfr_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // operation intake
    input  logic                            op_valid,
    output logic                            op_ready,
    input  olpfr_pkg::kind_t                op_kind,
    input  logic [olpfr_pkg::VALUE_W-1:0]   op_value,
    input  logic [olpfr_pkg::POS_W-1:0]     op_pos,
    // result handoff
    output logic                            res_valid,
    input  logic                            res_ready,
    output olpfr_pkg::result_t              res,
    // entry RAM
    output logic                            ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]  ram_waddr,
    output logic [olpfr_pkg::VALUE_W-1:0]   ram_wdata,
    output logic                            ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0]  ram_raddr,
    input  logic [olpfr_pkg::VALUE_W-1:0]   ram_rdata
);

    import olpfr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic [VALUE_W-1:0]  value_reg,  value_next;
    status_t             status_reg, status_next;
    logic [FOUND_W-1:0]  found_reg,  found_next;

    logic [CNT_W-1:0]         idx_inc;
    logic [POS_W+CNT_W-1:0]   pos_ext;
    logic [POS_W+CNT_W-1:0]   count_ext;
    logic [FOUND_W+CNT_W-1:0] idx_wide;
    logic [TOTAL_W+CNT_W-1:0] count_wide;

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign pos_ext    = {{CNT_W{1'b0}}, op_pos};
    assign count_ext  = {{POS_W{1'b0}}, count_reg};
    assign idx_wide   = {{FOUND_W{1'b0}}, idx_reg};
    assign count_wide = {{TOTAL_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        status_next = status_reg;
        found_next  = found_reg;
        op_ready    = (state_reg == S_IDLE);
        res_valid   = (state_reg == S_DONE);
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[IDX_W-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (op_valid) begin
                    value_next  = op_value;
                    found_next  = '0;
                    idx_next    = '0;
                    status_next = STAT_NOT_FOUND;
                    state_next  = S_DONE;
                    unique case (op_kind)
                        KIND_PUSH: begin
                            if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                                status_next = STAT_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[IDX_W-1:0];
                                ram_wdata   = op_value;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = STAT_OK;
                            end
                        end
                        KIND_FIND: begin
                            if (count_reg != '0) begin
                                state_next = S_FIND_RD;
                            end
                        end
                        KIND_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_NOT_FOUND;
                            end else if (pos_ext >= count_ext) begin
                                status_next = STAT_BOUNDS;
                            end else begin
                                idx_next    = pos_ext[CNT_W-1:0];
                                status_next = STAT_OK;
                                state_next  = S_SHIFT_RD;
                            end
                        end
                        default: begin
                            status_next = STAT_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                ram_re     = 1'b1;
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                // first match wins; stop at the end of the list otherwise
                if (ram_rdata == value_reg) begin
                    status_next = STAT_OK;
                    found_next  = idx_wide[FOUND_W-1:0];
                    state_next  = S_DONE;
                end else if (idx_inc == count_reg) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_FIND_RD;
                end
            end
            S_SHIFT_RD: begin
                if (idx_inc < count_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_inc[IDX_W-1:0];
                    state_next = S_SHIFT_WR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                // move the later entry down one place
                ram_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = S_SHIFT_RD;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status         = status_reg;
    assign res.found_position = found_reg;
    assign res.entry_total    = count_wide[TOTAL_W-1:0];

endmodule

[rtl/core/ordered_list_push_find_remove_core.sv]
// ----------------------------------------------------------------------------
// ordered_list_push_find_remove_core
// Ordered list of signed 32-bit values with push, find-first and
// remove-at-position, held in one RAM and walked by a small sequencer.
// ----------------------------------------------------------------------------
// Push, reserved and rejected operations go straight from idle to the result; find
// reads and compares each entry until the first match or the end of the list;
// remove reads each later entry and writes it one place down. The single registered
// RAM read port gives each entry walked a read state and a compare or write state.
// Throughput: one operation at a time; the next transfer can complete at the
// edge after the result enters the output register. Reset empties the list.
module ordered_list_push_find_remove_core #(
    parameter int TABLE_DEPTH = olpfr_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // operation channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [37:32] position, [39:38] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] found_position, [8:4] entry_total,
                                   // [15:9] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    import olpfr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    result_t             res;
    logic                res_valid;
    logic                res_ready;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg,   m_res_next;

    // Sequencer: decodes the operation and walks the entry RAM.
    olpfr_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (s_tvalid),
        .op_ready  (s_tready),
        .op_kind   (kind_t'(s_tuser)),
        .op_value  (s_tdata[VALUE_W-1:0]),
        .op_pos    (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Entry storage; entries at or above the count are never read.
    olpfr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: free when empty or when its transfer completes now.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        // load the finished result; sequencer holds it until then
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {7'd0, m_res_reg.entry_total, m_res_reg.found_position};

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list core. It sends push, find, remove
// and reserved operations, keeps its own copy of the list to work out each
// expected result, and checks every result transfer field by field. Both
// channels idle in random bursts, and one long receiver hold-off fills up
// the core.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import olpfr_pkg::*;

    localparam int LIST_DEPTH  = DEFAULT_TABLE_DEPTH;
    localparam int DRAIN_WAIT  = 2 + 2 * LIST_DEPTH + 8;   // worst walk plus margin
    localparam int POOL_SIZE   = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // [31:0] value, [37:32] position, [39:38] zero
    logic [1:0]  s_tuser  = '0;    // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [3:0] found_position, [8:4] entry_total, [15:9] zero
    logic [1:0]  m_tuser;          // [1:0] status

    // Predicted list contents and the results still owed by the core.
    logic [VALUE_W-1:0] list_mem [LIST_DEPTH];
    int                 list_len = 0;
    result_t            pending_results [$];
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    int  err_count    = 0;
    bit  tx_idle_en   = 1'b0;
    bit  rx_idle_en   = 1'b0;
    int  hold_request = 0;

    ordered_list_push_find_remove_core #(
        .TABLE_DEPTH(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Generous fixed limit: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // List predictor: apply one operation to the local copy and return the
    // result the core must produce for it.
    // ------------------------------------------------------------------------
    function automatic result_t apply_to_list(kind_t op, logic [VALUE_W-1:0] val,
                                              logic [POS_W-1:0] pos);
        result_t res;
        bit      hit;
        res.status         = STAT_NOT_FOUND;
        res.found_position = '0;
        hit                = 1'b0;
        case (op)
            KIND_PUSH: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                    res.status = STAT_OK;
                end
            end
            KIND_FIND: begin
                // first match wins
                for (int i = 0; i < list_len; i++) begin
                    if (!hit && list_mem[i] == val) begin
                        hit                = 1'b1;
                        res.status         = STAT_OK;
                        res.found_position = i[FOUND_W-1:0];
                    end
                end
            end
            KIND_REMOVE: begin
                if (list_len == 0) begin
                    res.status = STAT_NOT_FOUND;
                end else if (int'(pos) >= list_len) begin
                    res.status = STAT_BOUNDS;
                end else begin
                    // close the gap: shift later entries down one place
                    for (int i = int'(pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                    res.status = STAT_OK;
                end
            end
            default: begin
                // reserved kind leaves the list alone
            end
        endcase
        res.entry_total = list_len[TOTAL_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer one operation, hold it until the transfer, then record
    // the expected result. Call only right after a rising edge.
    // ------------------------------------------------------------------------
    task automatic send_op(kind_t op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            // drop valid for a short burst
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, pos, val};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_to_list(op, val, pos));
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin : rx_ready
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare every result transfer with the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_result
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d found %0d total %0d",
                       m_tuser, m_tdata[3:0], m_tdata[8:4]);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    err_count++;
                end
                if (m_tdata[3:0] !== want.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, m_tdata[3:0]);
                    err_count++;
                end
                if (m_tdata[8:4] !== want.entry_total) begin
                    $error("entry_total: expected %0d, got %0d",
                           want.entry_total, m_tdata[8:4]);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Operations on the empty list after reset.
    task automatic test_empty_list();
        send_op(KIND_REMOVE, 32'h0000_0000, 6'd63);   // empty beats out-of-bounds
        send_op(KIND_FIND, 32'h8000_0000, 6'd0);      // miss on empty list
        send_op(KIND_RESERVED, 32'hFFFF_FFFF, 6'd63);
    endtask

    // Fill to capacity with extreme and duplicate values, then overflow.
    task automatic test_fill_to_full();
        logic [VALUE_W-1:0] fill_vals [LIST_DEPTH];
        fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'h0000_0001, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                      32'h0000_0002, 32'h8000_0001, 32'hFFFF_FFFE, 32'h6789_ABCD};
        foreach (fill_vals[i])
            send_op(KIND_PUSH, fill_vals[i], 6'(i));
        send_op(KIND_PUSH, 32'h0BAD_F00D, 6'd0);      // list full
        send_op(KIND_FIND, 32'h7FFF_FFFF, 6'd0);      // duplicate: first copy wins
        send_op(KIND_FIND, 32'h6789_ABCD, 6'd0);      // last slot
    endtask

    // Remove at the boundaries of the full list.
    task automatic test_remove_edges();
        send_op(KIND_REMOVE, 32'h0, 6'(LIST_DEPTH));      // one past the end
        send_op(KIND_REMOVE, 32'h0, 6'(LIST_DEPTH - 1));  // last entry
        send_op(KIND_REMOVE, 32'h0, 6'd0);                // head: longest shift
    endtask

    // Random mix that swings the list between empty and full.
    task automatic test_random_mix(int n_ops);
        bit                 filling;
        int                 r;
        kind_t              op;
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]   pos;
        filling = 1'b1;
        for (int n = 0; n < n_ops; n++) begin
            if (list_len >= LIST_DEPTH)
                filling = 1'b0;
            else if (list_len == 0)
                filling = 1'b1;
            r = $urandom_range(0, 99);
            if (r < (filling ? 50 : 17))
                op = KIND_PUSH;
            else if (r < (filling ? 80 : 47))
                op = KIND_FIND;
            else if (r < 97)
                op = KIND_REMOVE;
            else
                op = KIND_RESERVED;

            // mostly pool values so finds hit, plus full-range noise
            r = $urandom_range(0, 9);
            if (op == KIND_FIND && list_len > 0 && r < 4)
                val = list_mem[$urandom_range(0, list_len - 1)];
            else if (r < 7)
                val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                val = $urandom;

            if (list_len > 0 && $urandom_range(0, 3) != 0)
                pos = 6'($urandom_range(0, list_len - 1));
            else
                pos = 6'($urandom_range(0, 63));

            send_op(op, val, pos);
        end
    endtask

    // Long receiver hold-off while operations keep coming.
    task automatic test_backpressure();
        hold_request = 300;
        test_random_mix(40);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_fill_to_full();
        test_remove_edges();

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_random_mix(500);
        test_backpressure();
        test_random_mix(450);

        // last stretch at full rate
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_mix(340);

        wait_drained();
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
